>>> rtl/mqss_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the multilevel queue slot scheduler: default sizes,
// wrap limit and result status codes. No dependencies.
package mqss_pkg;

  localparam int LEVELS_DEF   = 16;
  localparam int CAPACITY_DEF = 64;
  localparam int WRAP_LIMIT   = 2;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_GRANTED  = 2'd2,
    ST_NONE     = 2'd3
  } status_t;

endpackage

>>> rtl/multilevel_queue_slot_scheduler.sv
`timescale 1ns / 1ps
// Multilevel queue slot scheduler: per-level occupancy counts in a memory,
// plus a grant scan that walks the levels under a small sequencer.
// Depends on mqss_pkg.
//
// Enqueue steps through S_ENQ_RD, S_ENQ_WR and S_OUT. A grant scan spends
// S_PASS (one memory read) and S_EXAM (one examine) on each level visited,
// at most 2*LEVELS+1 levels. One item at a time: s_tready is high only when idle,
// and the next item is taken the cycle after the result is taken.
// Reset (rst, synchronous): all counts read as zero, level 0, budget LEVELS.
module multilevel_queue_slot_scheduler #(
  parameter int LEVELS         = mqss_pkg::LEVELS_DEF,
  parameter int LEVEL_CAPACITY = mqss_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [3:0] level, [7:4] zero
  input  logic       s_tuser,   // [0] req_type
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [3:0] granted_level, [7:4] zero
  output logic [1:0] m_tuser    // [1:0] status
);
  import mqss_pkg::*;

  localparam int LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW   = $clog2(LEVELS + 1);
  localparam int EW   = (CW > 4) ? CW : 4;
  localparam int CNTW = (LEVEL_CAPACITY > 1) ? $clog2(LEVEL_CAPACITY + 1) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_RD,
    S_ENQ_WR,
    S_PASS,
    S_EXAM,
    S_OUT
  } state_t;

  state_t          state;
  logic [3:0]      lvl;
  logic [CW-1:0]   cur;
  logic [CW-1:0]   budget;
  logic [1:0]      wraps;
  status_t         status;
  logic [3:0]      granted;

  // occupancy store with one valid bit per level
  logic [CNTW-1:0] counts [LEVELS];
  logic [LEVELS-1:0] vld;
  logic [CNTW-1:0] rd_data;
  logic            rd_vld;
  logic [LW-1:0]   rd_addr;
  logic            wr_en;
  logic [LW-1:0]   wr_addr;
  logic [CNTW-1:0] wr_data;

  logic            in_range;
  logic [LW-1:0]   lvl_addr;
  logic [CNTW-1:0] cnt;
  logic            wrap;
  logic [CW-1:0]   cur_inc;

  always_comb begin
    in_range = EW'(lvl) < EW'(LEVELS);
    lvl_addr = LW'(EW'(lvl));
    cnt      = rd_vld ? rd_data : '0;
    wrap     = cur >= CW'(LEVELS);
    cur_inc  = cur + CW'(1);
  end

  always_comb begin
    rd_addr = lvl_addr;
    if (state == S_PASS) begin
      rd_addr = wrap ? '0 : cur[LW-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = lvl_addr;
    wr_data = cnt + CNTW'(1);
    if (state == S_ENQ_WR) begin
      wr_en = in_range && (cnt < CNTW'(LEVEL_CAPACITY));
    end else if (state == S_EXAM) begin
      wr_en   = cnt != '0;
      wr_addr = cur[LW-1:0];
      wr_data = cnt - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= counts[rd_addr];
    rd_vld  <= vld[rd_addr];
    if (wr_en) begin
      counts[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cur     <= '0;
      budget  <= CW'(LEVELS);
      wraps   <= '0;
      lvl     <= '0;
      status  <= ST_ENQUEUED;
      granted <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            lvl     <= s_tdata[3:0];
            granted <= '0;
            wraps   <= '0;
            state   <= s_tuser ? S_PASS : S_ENQ_RD;
          end
        end
        S_ENQ_RD: begin
          state <= S_ENQ_WR;
        end
        S_ENQ_WR: begin
          status <= (in_range && (cnt < CNTW'(LEVEL_CAPACITY))) ? ST_ENQUEUED : ST_DROPPED;
          state  <= S_OUT;
        end
        S_PASS: begin
          // restart at level 0 with a full budget past the top level
          if (wrap) begin
            cur    <= '0;
            budget <= CW'(LEVELS);
            wraps  <= wraps + 2'd1;
          end
          state <= S_EXAM;
        end
        S_EXAM: begin
          if (cnt == '0) begin
            cur    <= cur_inc;
            budget <= CW'(LEVELS) - cur_inc;
            if (wraps == 2'(WRAP_LIMIT)) begin
              status <= ST_NONE;
              state  <= S_OUT;
            end else begin
              state <= S_PASS;
            end
          end else begin
            granted <= 4'(cur);
            status  <= ST_GRANTED;
            if (budget == CW'(1)) begin
              cur    <= cur_inc;
              budget <= CW'(LEVELS) - cur_inc;
            end else begin
              budget <= budget - CW'(1);
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = state == S_IDLE;
  assign m_tvalid = state == S_OUT;
  assign m_tdata  = {4'b0, granted};
  assign m_tuser  = status;

endmodule
